FILE: rtl/mtem_pkg.sv
// Shared types and constants for the multitap echo mixer core.
`timescale 1ns / 1ps

package mtem_pkg;

    // Defaults for the top-level parameters.
    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int MAX_TAPS_DEF      = 16;
    localparam int SAMPLE_BITS_DEF   = 16;

    // Fixed register widths.
    localparam int TAP_DELAY_BITS = 16;
    localparam int TAP_COUNT_BITS = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Iteration control.
    localparam int CNT_BITS        = 4;
    localparam int DIV_RADIX_STEPS = 4;
    localparam int REM_BITS        = 5;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TAP_DELAY      = 2'd0,
        CFG_TAP_COUNT      = 2'd1,
        CFG_ALT_POLARITY   = 2'd2,
        CFG_LINEAR_DIVISOR = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_STEP,
        ST_READ,
        ST_DATA,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/multitap_echo_mixer_core.sv
// Multitap feedforward echo mixer: history memory, tap sequencer and shared divider.
`timescale 1ns / 1ps

// The core mixes each input sample with up to MAX_TAPS earlier samples taken from a
// circular history memory of HISTORY_DEPTH entries, at distances of k times the tap
// delay for tap k. Each tap can take an alternating sign starting negative, and is
// divided with truncation toward zero by two to the k or by k+1. The sum of the
// current sample and all taps is halved toward zero and saturated to SAMPLE_BITS.
// One beat is handled at a time and the input stalls while it is in work. An item
// passes through an accept step, a step to reduce the tap delay modulo the depth
// (only when the delay is not below HISTORY_DEPTH, which never happens with the
// defaults), a step for the first address, then per tap a memory read, the read
// data and the accumulate, with the linear divisor also the shared divider between
// them, which retires four quotient bits a cycle, and a finishing step, which
// lasts longer while the output register still holds an untaken result. All taps
// share the single memory read port and the divider. The finished sample sits in an
// output register, so the next input beat is accepted while the previous result
// waits to be taken. No clearing pass is needed after reset: a history entry that
// has not been written since reset reads as zero, which is tracked by the write
// position and a wrapped flag. Configuration is written through a plain write
// port and is only to be changed while the core is idle.
module multitap_echo_mixer_core
    import mtem_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_TAPS      = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [SAMPLE_BITS-1:0]    i_in_sample,
    // Output channel.
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SAMPLE_BITS-1:0]    o_out_sample
);

    localparam int AW       = $clog2(HISTORY_DEPTH);
    localparam int ACC_W    = SAMPLE_BITS + 3;
    localparam int DIV_W    = ((SAMPLE_BITS + DIV_RADIX_STEPS - 1) / DIV_RADIX_STEPS)
                              * DIV_RADIX_STEPS;
    localparam int DIV_CYC  = DIV_W / DIV_RADIX_STEPS;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    // Reciprocal of the depth, rounded up, scaled so that the quotient of any delay
    // is exact.
    localparam int MOD_SHIFT = TAP_DELAY_BITS + AW;
    localparam int PROD_W    = MOD_SHIFT + TAP_DELAY_BITS;
    localparam logic [63:0] MOD_RECIP = ((64'd1 << MOD_SHIFT) + 64'(HISTORY_DEPTH - 1))
                                        / 64'(HISTORY_DEPTH);

    // Configuration registers.
    logic [TAP_DELAY_BITS-1:0] r_tap_delay;
    logic [TAP_COUNT_BITS-1:0] r_tap_count;
    logic                      r_alt_polarity;
    logic                      r_linear_div;

    // Sequencer and history bookkeeping.
    t_state                    r_state;
    t_state                    n_state;
    logic [AW-1:0]             r_wp;
    logic                      r_wrapped;

    // History memory and its registered read port.
    logic [SAMPLE_BITS-1:0]    r_mem [HISTORY_DEPTH];
    logic [SAMPLE_BITS-1:0]    r_rd_data;
    logic                      r_rd_ok;

    // Datapath registers.
    logic signed [ACC_W-1:0]   r_acc;
    logic [AW-1:0]             r_idx;
    logic [AW-1:0]             r_mod_rem;
    logic [TAP_DELAY_BITS-1:0] r_mod_q;
    logic [CNT_BITS-1:0]       r_cnt;
    logic [TAP_COUNT_BITS-1:0] r_k;
    logic [DIV_W-1:0]          r_quo;
    logic [REM_BITS-1:0]       r_rem;
    logic                      r_neg;

    // Output register.
    logic                      r_out_valid;
    logic [SAMPLE_BITS-1:0]    r_out_sample;

    // Handshake and control.
    logic                      in_accept;
    logic                      out_free;
    logic                      out_load;

    // Combinational datapath.
    logic [TAP_COUNT_BITS-1:0] taps;
    logic                      td_small;
    logic [PROD_W-1:0]         mod_prod;
    logic [TAP_DELAY_BITS-1:0] mod_quo;
    logic [31:0]               mod_sub;
    logic [AW:0]               idx_diff;
    logic [AW-1:0]             idx_next;
    logic [TAP_COUNT_BITS-1:0] tap_div;
    logic [SAMPLE_BITS-1:0]    tap_val;
    logic [SAMPLE_BITS-1:0]    tap_mag;
    logic [REM_BITS-1:0]       div_rem;
    logic [DIV_W-1:0]          div_quo;
    logic [REM_BITS:0]         div_trial;
    logic [ACC_W-1:0]          quo_ext;
    logic [ACC_W-1:0]          term;
    logic [ACC_W-1:0]          acc_rnd;
    logic signed [ACC_W-1:0]   acc_half;
    logic [SAMPLE_BITS-1:0]    sat_sample;

    // The tap count saturates at the number of taps the hardware supports.
    assign taps = (r_tap_count > TAP_COUNT_BITS'(MAX_TAPS)) ? TAP_COUNT_BITS'(MAX_TAPS)
                                                            : r_tap_count;

    // A delay below the depth needs no reduction.
    assign td_small = 32'(r_tap_delay) < 32'(HISTORY_DEPTH);

    // Delay modulo depth: the quotient comes from a multiplication by the constant
    // reciprocal, and in the following cycle the remainder from the registered quotient.
    assign mod_prod = PROD_W'(r_tap_delay) * PROD_W'(MOD_RECIP);
    assign mod_quo  = mod_prod[MOD_SHIFT +: TAP_DELAY_BITS];
    assign mod_sub  = 32'(r_tap_delay) - 32'(r_mod_q) * 32'(HISTORY_DEPTH);

    // Step back one tap delay through the circular history.
    always_comb begin
        idx_diff = {1'b0, r_idx} - {1'b0, r_mod_rem};
        if (idx_diff[AW]) begin
            idx_next = idx_diff[AW-1:0] + AW'(HISTORY_DEPTH);
        end else begin
            idx_next = idx_diff[AW-1:0];
        end
    end

    // Tap value and its magnitude; entries not yet written since reset read as zero.
    assign tap_val = r_rd_ok ? r_rd_data : '0;
    assign tap_mag = tap_val[SAMPLE_BITS-1] ? (~tap_val + 1'b1) : tap_val;
    assign tap_div = r_k + 1'b1;

    // Shared divider: four restoring quotient bits per cycle against the divisor k+1.
    always_comb begin
        div_rem   = r_rem;
        div_quo   = r_quo;
        div_trial = '0;
        for (int j = 0; j < DIV_RADIX_STEPS; j++) begin
            div_trial = {div_rem, div_quo[DIV_W-1]};
            div_quo   = {div_quo[DIV_W-2:0], 1'b0};
            if (div_trial >= {1'b0, tap_div}) begin
                div_trial  = div_trial - {1'b0, tap_div};
                div_quo[0] = 1'b1;
            end
            div_rem = div_trial[REM_BITS-1:0];
        end
    end

    // Signed tap term from the unsigned quotient.
    assign quo_ext = ACC_W'(r_quo);
    assign term    = r_neg ? (~quo_ext + 1'b1) : quo_ext;

    // Halve toward zero, then saturate to the sample width.
    assign acc_rnd  = r_acc + {{(ACC_W - 1){1'b0}}, r_acc[ACC_W-1]};
    assign acc_half = {acc_rnd[ACC_W-1], acc_rnd[ACC_W-1:1]};

    always_comb begin
        priority if (acc_half > SAT_MAX) begin
            sat_sample = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (acc_half < SAT_MIN) begin
            sat_sample = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            sat_sample = acc_half[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer outputs and handshake.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        in_accept  = i_in_valid && (r_state == ST_IDLE);
        out_free   = !r_out_valid || !i_out_stall;
        out_load   = (r_state == ST_FINISH) && out_free;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (!td_small) begin
                        n_state = ST_MOD;
                    end else if (taps == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_STEP;
                    end
                end
            end
            ST_MOD: begin
                n_state = (taps == '0) ? ST_FINISH : ST_STEP;
            end
            ST_STEP: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_DATA;
            end
            ST_DATA: begin
                n_state = r_linear_div ? ST_DIV : ST_ACC;
            end
            ST_DIV: begin
                if (r_cnt == CNT_BITS'(DIV_CYC - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = (r_k == taps) ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_wp           <= '0;
            r_wrapped      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tap_delay    <= '0;
            r_tap_count    <= TAP_COUNT_BITS'(1);
            r_alt_polarity <= 1'b0;
            r_linear_div   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_TAP_DELAY:      r_tap_delay    <= i_cfg_data[TAP_DELAY_BITS-1:0];
                    CFG_TAP_COUNT:      r_tap_count    <= i_cfg_data[TAP_COUNT_BITS-1:0];
                    CFG_ALT_POLARITY:   r_alt_polarity <= i_cfg_data[0];
                    CFG_LINEAR_DIVISOR: r_linear_div   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_wp == AW'(HISTORY_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // History memory: write of the incoming sample, registered read at the tap address.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mem[r_wp] <= i_in_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx];
        r_rd_ok   <= r_wrapped || (r_idx <= r_wp);
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_acc     <= {{(ACC_W - SAMPLE_BITS){i_in_sample[SAMPLE_BITS-1]}},
                                  i_in_sample};
                    r_idx     <= r_wp;
                    r_mod_q   <= mod_quo;
                    r_mod_rem <= td_small ? AW'(r_tap_delay) : '0;
                    r_cnt     <= '0;
                    r_k       <= TAP_COUNT_BITS'(1);
                end
            end
            ST_MOD: begin
                r_mod_rem <= mod_sub[AW-1:0];
            end
            ST_STEP: begin
                r_idx <= idx_next;
            end
            ST_READ: ;
            ST_DATA: begin
                r_neg <= tap_val[SAMPLE_BITS-1] ^ (r_alt_polarity && r_k[0]);
                r_rem <= '0;
                r_cnt <= '0;
                if (r_linear_div) begin
                    r_quo <= DIV_W'(tap_mag);
                end else begin
                    r_quo <= DIV_W'(tap_mag) >> r_k;
                end
            end
            ST_DIV: begin
                r_quo <= div_quo;
                r_rem <= div_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ACC: begin
                r_acc <= r_acc + term;
                r_k   <= r_k + 1'b1;
                r_idx <= idx_next;
            end
            ST_FINISH: begin
                if (out_load) begin
                    r_out_sample <= sat_sample;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

`ifndef SYNTHESIS
    // The divider only runs with linear divisors.
    a_div_only_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_linear_div)
        else $error("divider active with power-of-two divisors");

    // An accepted beat always starts the sequencer.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_MOD || r_state == ST_STEP || r_state == ST_FINISH))
        else $error("accepted beat did not start the sequencer");

    // The tap counter never runs past the effective tap count.
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_k >= TAP_COUNT_BITS'(1) && r_k <= taps))
        else $error("tap counter out of range");

    // A finished item lands in the output register and frees the input.
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished result not loaded");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the multitap echo mixer core: predictor, stimulus and checks.
`timescale 1ns / 1ps

import mtem_pkg::*;

typedef logic [SAMPLE_BITS_DEF-1:0] t_sample;

// Keeps its own copy of the echo history and the registers, predicts the mixed
// sample for every accepted input beat and checks the output beats in order.
class mix_scoreboard;
    t_sample                   history [HISTORY_DEPTH_DEF];
    int                        write_pos;
    logic [TAP_DELAY_BITS-1:0] tap_delay;
    logic [TAP_COUNT_BITS-1:0] tap_count;
    logic                      alt_polarity;
    logic                      linear_div;
    t_sample                   expected_mix [$];
    int                        failures;

    function new();
        foreach (history[i]) history[i] = '0;
        write_pos    = 0;
        tap_delay    = '0;
        tap_count    = TAP_COUNT_BITS'(1);
        alt_polarity = 1'b0;
        linear_div   = 1'b0;
        failures     = 0;
    endfunction

    function void write_reg(t_cfg_reg idx, logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_TAP_DELAY:      tap_delay    = data[TAP_DELAY_BITS-1:0];
            CFG_TAP_COUNT:      tap_count    = data[TAP_COUNT_BITS-1:0];
            CFG_ALT_POLARITY:   alt_polarity = data[0];
            CFG_LINEAR_DIVISOR: linear_div   = data[0];
            default: ;
        endcase
    endfunction

    // The new sample goes into the history first, so a zero delay reads it back.
    function void note_sample(t_sample raw);
        longint peak;
        longint acc;
        longint tap_val;
        longint divisor;
        longint back;
        int     idx;
        int     taps;
        peak = (longint'(1) << (SAMPLE_BITS_DEF - 1)) - 1;
        history[write_pos] = raw;
        acc  = longint'($signed(raw));
        taps = (tap_count > MAX_TAPS_DEF) ? MAX_TAPS_DEF : int'(tap_count);
        for (int k = 1; k <= taps; k++) begin
            back    = (longint'(k) * longint'(tap_delay)) % HISTORY_DEPTH_DEF;
            idx     = int'((write_pos + HISTORY_DEPTH_DEF - back) % HISTORY_DEPTH_DEF);
            tap_val = longint'($signed(history[idx]));
            divisor = linear_div ? longint'(k + 1) : (longint'(1) << k);
            if (alt_polarity && (k % 2 == 1)) begin
                tap_val = -tap_val;
            end
            acc += tap_val / divisor;
        end
        acc = acc / 2;
        if (acc > peak) acc = peak;
        if (acc < -peak - 1) acc = -peak - 1;
        expected_mix.push_back(acc[SAMPLE_BITS_DEF-1:0]);
        write_pos = (write_pos + 1) % HISTORY_DEPTH_DEF;
    endfunction

    function void check_result(t_sample actual);
        t_sample want;
        if (expected_mix.size() == 0) begin
            $error("out_sample: expected none, actual %0d", $signed(actual));
            failures++;
        end else begin
            want = expected_mix.pop_front();
            if (want !== actual) begin
                $error("out_sample: expected %0d, actual %0d", $signed(want), $signed(actual));
                failures++;
            end
        end
    endfunction

    function int pending();
        return expected_mix.size();
    endfunction
endclass

module tb_top;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_TAP_DELAY;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    t_sample                   i_in_sample = '0;
    logic                      i_out_stall = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    t_sample                   o_out_sample;

    mix_scoreboard board = new();

    // Idle percentages per cycle for both sides; the stimulus changes them per stretch.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // A long receiver hold-off is requested here and counted down by the receiver.
    int hold_left   = 0;

    multitap_echo_mixer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The run should need well under a fifth of this even with every tap in use.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Output side: a beat is taken when valid is high and our stall was low at the
    // edge. The stall for the next cycle is chosen right after, either from the
    // running idle percentage or from a pending long hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                board.check_result(o_out_sample);
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // One register write per clock; the caller lowers the write enable afterwards.
    task automatic cfg_write(t_cfg_reg idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Writes all four registers. The bits above each register's width carry random
    // junk, which the core must ignore.
    task automatic apply_settings(logic [TAP_DELAY_BITS-1:0] delay,
                                  logic [TAP_COUNT_BITS-1:0] count, bit alt, bit lin);
        logic [CFG_DATA_BITS-1:0] count_word;
        logic [CFG_DATA_BITS-1:0] alt_word;
        logic [CFG_DATA_BITS-1:0] lin_word;
        count_word = CFG_DATA_BITS'($urandom());
        count_word[TAP_COUNT_BITS-1:0] = count;
        alt_word = CFG_DATA_BITS'($urandom());
        alt_word[0] = alt;
        lin_word = CFG_DATA_BITS'($urandom());
        lin_word[0] = lin;
        cfg_write(CFG_TAP_DELAY, delay);
        cfg_write(CFG_TAP_COUNT, count_word);
        cfg_write(CFG_ALT_POLARITY, alt_word);
        cfg_write(CFG_LINEAR_DIVISOR, lin_word);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one sample beat and holds it until it is taken. Valid stays high into
    // the next beat unless a gap is drawn, so back-to-back beats never drop valid.
    task automatic send_sample(t_sample s);
        int gap;
        i_in_valid  <= 1'b1;
        i_in_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(s);
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering beats until every predicted sample has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sample mix: plenty of loud values so that saturation is reached, some quiet
    // ones, the two's complement corners, and full-range random values.
    function automatic t_sample pick_sample();
        t_sample s;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: s = 16'h7fff;
                    1: s = 16'h8000;
                    2: s = 16'h0000;
                    default: s = 16'hffff;
                endcase
            end
            1, 2: begin
                s = t_sample'($urandom_range(20000, 32767));
                if ($urandom_range(0, 1)) s = -s;
            end
            3: s = t_sample'(int'($urandom_range(0, 128)) - 64);
            default: s = t_sample'($urandom());
        endcase
        return s;
    endfunction

    // Delays: small ones keep the taps inside written history, multiples of large
    // powers of two fold k times the delay back onto the current sample, and
    // values near the depth wrap around to entries just ahead of the write point.
    function automatic logic [TAP_DELAY_BITS-1:0] pick_delay();
        logic [TAP_DELAY_BITS-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1, 2, 3: d = TAP_DELAY_BITS'($urandom_range(1, 8));
            4, 5:    d = TAP_DELAY_BITS'($urandom_range(9, 300));
            6:       d = 16'(($urandom_range(1, 7)) * 8192);
            7:       d = 16'(HISTORY_DEPTH_DEF - int'($urandom_range(1, 8)));
            default: d = TAP_DELAY_BITS'($urandom());
        endcase
        return d;
    endfunction

    function automatic logic [TAP_COUNT_BITS-1:0] pick_count();
        logic [TAP_COUNT_BITS-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = '0;
            1:       c = TAP_COUNT_BITS'($urandom_range(MAX_TAPS_DEF + 1, 31));
            2:       c = TAP_COUNT_BITS'(MAX_TAPS_DEF);
            default: c = TAP_COUNT_BITS'($urandom_range(1, MAX_TAPS_DEF));
        endcase
        return c;
    endfunction

    initial begin
        int      mode;
        t_sample corners [7];

        corners = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one tap at zero delay, which reads back the current sample.
        foreach (corners[i]) send_sample(corners[i]);
        drain_results();

        // No taps at all, so the output is just the halved input.
        apply_settings(16'hffff, 5'd0, 1'b1, 1'b1);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h3039);
        drain_results();

        // A tap count above the maximum saturates to sixteen taps; with linear
        // divisors a run of full-scale samples overflows the sum both ways.
        apply_settings(16'd1, 5'd31, 1'b0, 1'b1);
        repeat (6) send_sample(16'h7fff);
        repeat (6) send_sample(16'h8000);
        drain_results();

        // Alternating polarity with zero delay: every tap reads the current sample.
        apply_settings(16'd0, TAP_COUNT_BITS'(MAX_TAPS_DEF), 1'b1, 1'b0);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        drain_results();

        // Random phases. Each one runs under its own settings and idle pattern;
        // the settings only change once the core has gone quiet.
        for (int ph = 0; ph < 12; ph++) begin
            mode = ph % 4;
            apply_settings(pick_delay(), pick_count(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));

            // Hold the output off for a long stretch while beats keep coming, so
            // the core fills up and stalls its input.
            if (ph == 2) begin
                hold_left = 600;
            end

            for (int n = 0; n < 75; n++) begin
                // Idle patterns change every 15 beats, with quiet stretches mixed in.
                if (n % 15 == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end else begin
                        tx_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 26 : 0;
                        rx_idle_pct = (mode == 2) ? 51 : (mode == 3) ? 26 : 0;
                    end
                end
                // Once, the sender pauses until all outstanding results are back.
                if (ph == 5 && n == 37) begin
                    drain_results();
                end
                send_sample(pick_sample());
            end
            drain_results();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Leave time for any stray beat that the core might still put out.
        repeat (150) @(posedge i_clk);

        if (board.failures == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/mtem_pkg.sv
rtl/multitap_echo_mixer_core.sv
verif/tb_top.sv
